>>> rtl/core/ofr_pkg.sv
// ----------------------------------------------------------------------------
// ofr_pkg
// Types and constants shared by the observation frame receiver.
// ----------------------------------------------------------------------------
package ofr_pkg;

	localparam int FRAME_BYTES = 22;
	localparam int CRC_BYTES   = 20;
	localparam int IDX_W       = 5;

	localparam logic [7:0]  HDR0       = 8'hAA;
	localparam logic [7:0]  HDR1       = 8'h55;
	localparam logic [15:0] COORD_NONE = 16'hFFFF;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [15:0] SEQ_HALF   = 16'h8000;
	localparam logic [7:0]  TRACK_MAX  = 8'd4;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_ACCEPT  = 3'd1,
		EV_CRC     = 3'd2,
		EV_VERSION = 3'd3,
		EV_TYPE    = 3'd4,
		EV_FIELD   = 3'd5,
		EV_DUP     = 3'd6,
		EV_ORDER   = 3'd7
	} event_t;

	typedef enum logic [2:0] {
		CFG_VERSION = 3'd0,
		CFG_MSGTYPE = 3'd1,
		CFG_FLAGS   = 3'd2,
		CFG_RECT    = 3'd3,
		CFG_LASER   = 3'd4,
		CFG_WIDTH   = 3'd5,
		CFG_HEIGHT  = 3'd6,
		CFG_TIMEOUT = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [14:0] dropped_count;
		logic        rebased;
		logic [15:0] sequence_res;
		logic [31:0] sender_time;
		logic [15:0] rect_x;
		logic [15:0] rect_y;
		logic [15:0] laser_x;
		logic [15:0] laser_y;
		logic [7:0]  valid_flags;
		logic [2:0]  tracking_state;
		logic [31:0] receive_time;
	} result_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic [31:0] now_ms;
	} item_t;

	// one byte of CRC-16/CCITT-FALSE, eight dependent shifts on 16 bits
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
		logic [15:0] c;
		c = crc ^ {d, 8'h00};
		for (int b = 0; b < 8; b++) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

endpackage

>>> rtl/core/ofr_stream_if.sv
// ----------------------------------------------------------------------------
// ofr_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface ofr_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/observation_frame_receiver.sv
// ----------------------------------------------------------------------------
// observation_frame_receiver
// Serial frame parser: header hunt, CRC and field checks, sequence tracking.
// ----------------------------------------------------------------------------
// Each input word (a byte and the millisecond time) yields exactly one result
// word. A byte that does not complete a frame goes through the memory write,
// the result hand-off and the output handshake before the next accept. The
// byte that completes a 22-byte frame starts a pass over the frame memory, one
// registered read per cycle: 21 reads of bytes 0..20 fold the CRC over bytes
// 0..19 and fill a register copy, byte 21 comes straight from the input word,
// then the checks. A failed frame then scans the copy for an inner header and
// moves the kept bytes to the front of memory, one read and one write per
// byte, up to 21 bytes. The frame memory has a single read port.
// No clearing pass.
module observation_frame_receiver
	import ofr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	ofr_stream_if.sink   in_ch,
	ofr_stream_if.source out_ch
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_MOVE  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		PH_WAIT0   = 2'd0,
		PH_WAIT1   = 2'd1,
		PH_COLLECT = 2'd2
	} phase_t;

	// configuration
	logic [7:0]  version_q, msgtype_q, flagmask_q, rectmask_q, lasermask_q;
	logic [15:0] width_q, height_q;
	logic [31:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q   <= 8'd1;
			msgtype_q   <= 8'd1;
			flagmask_q  <= 8'd3;
			rectmask_q  <= 8'd1;
			lasermask_q <= 8'd2;
			width_q     <= 16'd320;
			height_q    <= 16'd240;
			timeout_q   <= 32'd500;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_VERSION: version_q   <= cfg_data[7:0];
				CFG_MSGTYPE: msgtype_q   <= cfg_data[7:0];
				CFG_FLAGS:   flagmask_q  <= cfg_data[7:0];
				CFG_RECT:    rectmask_q  <= cfg_data[7:0];
				CFG_LASER:   lasermask_q <= cfg_data[7:0];
				CFG_WIDTH:   width_q     <= cfg_data[15:0];
				CFG_HEIGHT:  height_q    <= cfg_data[15:0];
				CFG_TIMEOUT: timeout_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame memory, one write and one registered read per cycle
	logic [7:0] mem [FRAME_BYTES];
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa, mem_ra;
	logic [7:0]        mem_wd, mem_rd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd <= mem[mem_ra];
	end

	state_t           state_q;
	phase_t           phase_q;
	logic [IDX_W-1:0] fill_q, ptr_q, rd_idx_q, src_q, cnt_q;
	logic             have_base_q;
	logic [15:0]      last_seq_q;
	logic [31:0]      last_time_q, now_q;
	logic [15:0]      crc_q;
	logic [7:0]       f [FRAME_BYTES];
	logic             rd_vld_q;
	result_t          res_q;
	logic             out_vld_q;

	assign in_ch.ready    = (state_q == ST_IDLE) && !out_vld_q;
	assign out_ch.valid   = out_vld_q;
	assign out_ch.payload = res_q;

	logic in_fire;
	assign in_fire = in_ch.valid && in_ch.ready;

	// field checks on the captured frame copy
	logic [15:0] rx, ry, lx, ly, crc_rx, seq, delta;
	logic [7:0]  flags;
	logic        ok_rx, ok_ry, ok_lx, ok_ly, pr, pl, rebase;
	event_t      err;
	always_comb begin
		rx = {f[11], f[10]};
		ry = {f[13], f[12]};
		lx = {f[15], f[14]};
		ly = {f[17], f[16]};
		crc_rx = {f[21], f[20]};
		flags = f[18];
		ok_rx = rx < width_q  || rx == COORD_NONE;
		ok_ry = ry < height_q || ry == COORD_NONE;
		ok_lx = lx < width_q  || lx == COORD_NONE;
		ok_ly = ly < height_q || ly == COORD_NONE;
		pr = ((flags & rectmask_q) != 8'd0) ? (rx < width_q && ry < height_q)
			: (rx == COORD_NONE && ry == COORD_NONE);
		pl = ((flags & lasermask_q) != 8'd0) ? (lx < width_q && ly < height_q)
			: (lx == COORD_NONE && ly == COORD_NONE);
		if (crc_q != crc_rx)                                    err = EV_CRC;
		else if (f[2] != version_q)                             err = EV_VERSION;
		else if (f[3] != msgtype_q)                             err = EV_TYPE;
		else if ((flags & ~flagmask_q) != 8'd0)                 err = EV_FIELD;
		else if (f[19] > TRACK_MAX)                             err = EV_FIELD;
		else if (!(ok_rx && ok_ry && ok_lx && ok_ly && pr && pl)) err = EV_FIELD;
		else                                                    err = EV_NONE;
		seq = {f[5], f[4]};
		delta = seq - last_seq_q;
		rebase = !have_base_q || ((now_q - last_time_q) > timeout_q);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = fill_q;
		mem_wd = in_ch.payload.rx_byte;
		mem_ra = ptr_q;
		if (in_fire) begin
			case (phase_q)
				PH_WAIT0:   begin mem_we = (in_ch.payload.rx_byte == HDR0); mem_wa = '0; end
				PH_WAIT1:   begin mem_we = (in_ch.payload.rx_byte == HDR1); mem_wa = 5'd1; end
				PH_COLLECT: mem_we = (fill_q < IDX_W'(FRAME_BYTES));
				default: ;
			endcase
		end else if (state_q == ST_MOVE && rd_vld_q) begin
			mem_we = 1'b1;
			mem_wa = cnt_q;
			mem_wd = mem_rd;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) now_q <= in_ch.payload.now_ms;
		if (state_q == ST_READ && rd_vld_q) f[rd_idx_q] <= mem_rd;
		if (in_fire) f[FRAME_BYTES-1] <= in_ch.payload.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_WAIT0;
			fill_q      <= '0;
			ptr_q       <= '0;
			rd_idx_q    <= '0;
			src_q       <= '0;
			cnt_q       <= '0;
			rd_vld_q    <= 1'b0;
			have_base_q <= 1'b0;
			last_seq_q  <= '0;
			last_time_q <= '0;
			crc_q       <= CRC_INIT;
			out_vld_q   <= 1'b0;
			res_q       <= '0;
		end else begin
			if (out_vld_q && out_ch.ready) out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						res_q <= '0;
						state_q <= ST_OUT;
						case (phase_q)
							PH_WAIT0: if (in_ch.payload.rx_byte == HDR0) begin
								fill_q <= 5'd1; phase_q <= PH_WAIT1;
							end
							PH_WAIT1: if (in_ch.payload.rx_byte == HDR1) begin
								fill_q <= 5'd2; phase_q <= PH_COLLECT;
							end else if (in_ch.payload.rx_byte != HDR0) begin
								fill_q <= '0; phase_q <= PH_WAIT0;
							end
							PH_COLLECT: begin
								if (fill_q >= IDX_W'(FRAME_BYTES)) begin
									fill_q <= '0; phase_q <= PH_WAIT0;
								end else if (fill_q == IDX_W'(FRAME_BYTES - 1)) begin
									fill_q <= IDX_W'(FRAME_BYTES);
									ptr_q <= '0; rd_vld_q <= 1'b0;
									crc_q <= CRC_INIT;
									state_q <= ST_READ;
								end else begin
									fill_q <= fill_q + 5'd1;
								end
							end
							default: begin fill_q <= '0; phase_q <= PH_WAIT0; end
						endcase
					end
				end
				ST_READ: begin
					// stream bytes 0..20 out of memory, fold CRC over 0..19
					rd_vld_q <= 1'b1;
					rd_idx_q <= ptr_q;
					ptr_q <= ptr_q + 5'd1;
					if (rd_vld_q && rd_idx_q < IDX_W'(CRC_BYTES))
						crc_q <= crc_byte(crc_q, mem_rd);
					if (rd_vld_q && rd_idx_q == IDX_W'(FRAME_BYTES - 2)) begin
						rd_vld_q <= 1'b0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_OUT;
					if (err == EV_NONE) begin
						fill_q <= '0; phase_q <= PH_WAIT0;
						if (!rebase && delta == 16'd0) res_q.event_res <= EV_DUP;
						else if (!rebase && delta >= SEQ_HALF) res_q.event_res <= EV_ORDER;
						else begin
							have_base_q <= 1'b1;
							last_seq_q  <= seq;
							last_time_q <= now_q;
							res_q.event_res      <= EV_ACCEPT;
							res_q.dropped_count  <= rebase ? 15'd0 : 15'(delta - 16'd1);
							res_q.rebased        <= rebase;
							res_q.sequence_res   <= seq;
							res_q.sender_time    <= {f[9], f[8], f[7], f[6]};
							res_q.rect_x         <= rx;
							res_q.rect_y         <= ry;
							res_q.laser_x        <= lx;
							res_q.laser_y        <= ly;
							res_q.valid_flags    <= flags;
							res_q.tracking_state <= f[19][2:0];
							res_q.receive_time   <= now_q;
						end
					end else begin
						res_q.event_res <= err;
						src_q <= 5'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// find the first AA 55 pair at offsets 1..20 in the copy
					if (f[src_q] == HDR0 && f[src_q + 5'd1] == HDR1) begin
						ptr_q <= src_q; cnt_q <= '0; rd_vld_q <= 1'b0;
						fill_q <= IDX_W'(FRAME_BYTES) - src_q;
						phase_q <= PH_COLLECT;
						state_q <= ST_MOVE;
					end else if (src_q == IDX_W'(FRAME_BYTES - 2)) begin
						state_q <= ST_OUT;
						if (f[FRAME_BYTES-1] == HDR0) begin
							fill_q <= 5'd1; phase_q <= PH_WAIT1;
							// byte 0 of memory must read AA
							ptr_q <= IDX_W'(FRAME_BYTES - 1); cnt_q <= '0;
							rd_vld_q <= 1'b0; state_q <= ST_MOVE;
							src_q <= IDX_W'(FRAME_BYTES - 1);
						end else begin
							fill_q <= '0; phase_q <= PH_WAIT0;
						end
					end else begin
						src_q <= src_q + 5'd1;
					end
				end
				ST_MOVE: begin
					// copy memory[ptr..21] down to memory[0..]
					if (ptr_q < IDX_W'(FRAME_BYTES)) ptr_q <= ptr_q + 5'd1;
					rd_vld_q <= (ptr_q < IDX_W'(FRAME_BYTES));
					if (rd_vld_q) cnt_q <= cnt_q + 5'd1;
					if (rd_vld_q && ptr_q == IDX_W'(FRAME_BYTES)) begin
						rd_vld_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					out_vld_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the input side is closed while a result waits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !in_ch.ready) else $error("input taken over pending result");
	// an accept that rebases always leaves the base valid
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && err == EV_NONE && rebase) |=> have_base_q)
		else $error("rebase did not set base");
	// fill never runs past the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= IDX_W'(FRAME_BYTES)) else $error("fill index overflow");

endmodule
